// ----- sv/rvs_pkg.sv -----
// rvs_pkg: shared types and constants of the RV32 subset execute core.
// Used by rvs_front, rvs_back and the top level; depends on nothing.
package rvs_pkg;

   localparam int unsigned XLEN           = 32;
   localparam int unsigned DMEM_DEPTH_DEF = 1024;
   localparam int unsigned REG_COUNT      = 32;
   localparam int unsigned REG_AW         = 5;
   localparam int unsigned QUEUE_DEPTH    = 2;

   localparam logic [6:0] OP_R      = 7'd51;
   localparam logic [6:0] OP_I      = 7'd19;
   localparam logic [6:0] OP_LOAD   = 7'd3;
   localparam logic [6:0] OP_STORE  = 7'd35;
   localparam logic [6:0] OP_BRANCH = 7'd99;
   localparam logic [6:0] OP_LUI    = 7'd55;
   localparam logic [6:0] OP_JAL    = 7'd111;
   localparam logic [6:0] OP_JALR   = 7'd103;
   localparam logic [6:0] OP_AUIPC  = 7'd23;

   localparam logic [6:0] F7_BASE = 7'd0;
   localparam logic [6:0] F7_ALT  = 7'd32;
   localparam logic [6:0] F7_MUL  = 7'd1;

   localparam logic [2:0] F3_ADD  = 3'd0;
   localparam logic [2:0] F3_SLL  = 3'd1;
   localparam logic [2:0] F3_SLT  = 3'd2;
   localparam logic [2:0] F3_XOR  = 3'd4;
   localparam logic [2:0] F3_SR   = 3'd5;
   localparam logic [2:0] F3_OR   = 3'd6;
   localparam logic [2:0] F3_AND  = 3'd7;
   localparam logic [2:0] F3_BEQ  = 3'd0;
   localparam logic [2:0] F3_BNE  = 3'd1;
   localparam logic [2:0] F3_BLT  = 3'd4;
   localparam logic [2:0] F3_BGE  = 3'd5;
   localparam logic [2:0] F3_WORD = 3'd2;

   localparam logic [1:0] ST_OK      = 2'd0;
   localparam logic [1:0] ST_ILLEGAL = 2'd1;
   localparam logic [1:0] ST_DIVZERO = 2'd2;

   localparam logic ACT_EXEC    = 1'b0;
   localparam logic ACT_PRELOAD = 1'b1;

   typedef enum logic [1:0] {
      KIND_PRELOAD,
      KIND_LOAD,
      KIND_DIVREM,
      KIND_OTHER
   } kind_type;

   typedef struct packed {
      kind_type    kind;
      logic [31:0] instr_word;
      logic [31:0] preload_addr;
      logic [31:0] preload_data;
   } item_type;

endpackage

// ----- sv/rvs_ram.sv -----
// rvs_ram: generic single-write, single-read RAM with registered read data.
// No dependencies.
module rvs_ram #(
   parameter int unsigned WIDTH = 32,
   parameter int unsigned DEPTH = 32
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      rd_data_ff <= mem_ff[rd_addr];
   end

   assign rd_data = rd_data_ff;

endmodule

// ----- sv/rvs_front.sv -----
// rvs_front: accepts request transactions, classifies them and queues them.
// Depends on rvs_pkg.
module rvs_front (
   input  logic              clock,
   input  logic              reset,
   input  logic              clearing,
   input  logic              req_tvalid,
   output logic              req_tready,
   input  logic [95:0]       req_tdata,
   input  logic              req_tuser,
   output rvs_pkg::item_type head,
   output logic              head_valid,
   input  logic              pop
);

   localparam int unsigned QD = rvs_pkg::QUEUE_DEPTH;
   localparam int unsigned QW = $clog2(QD);

   rvs_pkg::item_type q_ff [QD];
   logic [QW-1:0]     wr_ptr_ff, rd_ptr_ff;
   logic [QW:0]       count_ff;
   rvs_pkg::item_type item_in;
   logic              push;
   logic [6:0]        op;
   logic [2:0]        f3;
   logic [6:0]        f7;

   assign op = req_tdata[6:0];
   assign f3 = req_tdata[14:12];
   assign f7 = req_tdata[31:25];

   always_comb begin
      item_in.instr_word   = req_tdata[31:0];
      item_in.preload_addr = req_tdata[63:32];
      item_in.preload_data = req_tdata[95:64];
      if (req_tuser == rvs_pkg::ACT_PRELOAD) begin
         item_in.kind = rvs_pkg::KIND_PRELOAD;
      end else if (op == rvs_pkg::OP_LOAD && f3 <= rvs_pkg::F3_WORD) begin
         item_in.kind = rvs_pkg::KIND_LOAD;
      end else if (op == rvs_pkg::OP_R && f7 == rvs_pkg::F7_MUL
                   && (f3 == rvs_pkg::F3_XOR || f3 == rvs_pkg::F3_OR)) begin
         item_in.kind = rvs_pkg::KIND_DIVREM;
      end else begin
         item_in.kind = rvs_pkg::KIND_OTHER;
      end
   end

   assign req_tready = (count_ff != (QW+1)'(QD)) && !clearing;
   assign push       = req_tvalid && req_tready;
   assign head       = q_ff[rd_ptr_ff];
   assign head_valid = count_ff != '0;

   always_ff @(posedge clock) begin
      if (push) begin
         q_ff[wr_ptr_ff] <= item_in;
      end
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         if (push) begin
            wr_ptr_ff <= (wr_ptr_ff == QW'(QD-1)) ? '0 : wr_ptr_ff + 1'b1;
         end
         if (pop) begin
            rd_ptr_ff <= (rd_ptr_ff == QW'(QD-1)) ? '0 : rd_ptr_ff + 1'b1;
         end
         count_ff <= count_ff + (QW+1)'(push) - (QW+1)'(pop);
      end
   end

endmodule

// ----- sv/rvs_div.sv -----
// rvs_div: signed 32-bit divide/remainder, one quotient bit per cycle.
// No dependencies.
module rvs_div (
   input  logic        clock,
   input  logic        reset,
   input  logic        start,
   input  logic        want_rem,
   input  logic [31:0] dividend,
   input  logic [31:0] divisor,
   output logic        done,
   output logic [31:0] result
);

   logic [31:0] rem_ff;
   logic [31:0] quo_ff, div_ff;
   logic [4:0]  count_ff;
   logic        busy_ff, done_ff, negq_ff, negr_ff, rem_sel_ff;
   logic [32:0] shifted, diff;

   assign shifted = {rem_ff, quo_ff[31]};
   assign diff    = shifted - {1'b0, div_ff};

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
      end else if (start) begin
         busy_ff    <= 1'b1;
         done_ff    <= 1'b0;
         count_ff   <= 5'd31;
         rem_ff     <= '0;
         quo_ff     <= dividend[31] ? 32'd0 - dividend : dividend;
         div_ff     <= divisor[31] ? 32'd0 - divisor : divisor;
         negq_ff    <= dividend[31] ^ divisor[31];
         negr_ff    <= dividend[31];
         rem_sel_ff <= want_rem;
      end else if (busy_ff) begin
         if (diff[32]) begin
            rem_ff <= shifted[31:0];
            quo_ff <= {quo_ff[30:0], 1'b0};
         end else begin
            rem_ff <= diff[31:0];
            quo_ff <= {quo_ff[30:0], 1'b1};
         end
         count_ff <= count_ff - 1'b1;
         if (count_ff == '0) begin
            busy_ff <= 1'b0;
            done_ff <= 1'b1;
         end
      end
   end

   assign done   = done_ff;
   assign result = rem_sel_ff ? (negr_ff ? 32'd0 - rem_ff : rem_ff)
                              : (negq_ff ? 32'd0 - quo_ff : quo_ff);

endmodule

// ----- sv/rvs_back.sv -----
// rvs_back: executes queued items; holds pc, register file, data store, result register.
// Depends on rvs_pkg, rvs_ram and rvs_div.
module rvs_back #(
   parameter int unsigned DMEM_DEPTH = rvs_pkg::DMEM_DEPTH_DEF
) (
   input  logic              clock,
   input  logic              reset,
   input  rvs_pkg::item_type head,
   input  logic              head_valid,
   output logic              pop,
   output logic              clearing,
   output logic              rsp_valid,
   input  logic              rsp_ready,
   output logic [31:0]       o_item_pc,
   output logic [31:0]       o_next_pc,
   output logic              o_wb_enable,
   output logic [4:0]        o_wb_reg,
   output logic [31:0]       o_wb_value,
   output logic              o_store_enable,
   output logic [31:0]       o_mem_address,
   output logic [1:0]        o_status
);

   localparam int unsigned AW = $clog2(DMEM_DEPTH);

   typedef enum logic [2:0] {S_CLR, S_IDLE, S_EXEC, S_LOAD, S_DIV} state_type;

   state_type         state_ff;
   rvs_pkg::item_type item_ff;
   logic [31:0]       pc_ff, addr_pend_ff;
   logic [AW-1:0]     clr_ff;
   logic [31:0]       rf_valid_ff;
   logic              rsp_valid_ff;
   logic [31:0]       item_pc_ff, next_pc_ff, wb_value_ff, mem_address_ff;
   logic              wb_enable_ff, store_enable_ff;
   logic [4:0]        wb_reg_ff;
   logic [1:0]        status_ff;

   logic [31:0] rf_a_rd, rf_b_rd, a, b, w;
   logic [4:0]  rs1, rs2, rd, rf_rs1_addr, rf_rs2_addr;
   logic [6:0]  op, f7;
   logic [2:0]  f3;
   logic [31:0] immi, imms, immb, immj, immu;
   logic [31:0] prod;
   logic [31:0] ex_next, ex_v, ex_addr;
   logic        ex_wr, ex_st;
   logic [1:0]  ex_status;
   logic        out_free, go, div_start, div_done;
   logic [31:0] div_result, dm_rd;
   logic        dm_we;
   logic [AW-1:0] dm_waddr;
   logic [31:0] dm_wdata;
   logic        rf_we;
   logic [4:0]  rf_wa;
   logic [31:0] rf_wd;

   assign out_free = !rsp_valid_ff || rsp_ready;
   assign pop      = (state_ff == S_IDLE) && head_valid;
   assign clearing = state_ff == S_CLR;
   assign go       = (state_ff == S_EXEC) && out_free;

   assign w   = item_ff.instr_word;
   assign op  = w[6:0];
   assign rd  = w[11:7];
   assign f3  = w[14:12];
   assign rs1 = w[19:15];
   assign rs2 = w[24:20];
   assign f7  = w[31:25];
   assign a   = (rf_valid_ff[rs1] && rs1 != '0) ? rf_a_rd : '0;
   assign b   = (rf_valid_ff[rs2] && rs2 != '0) ? rf_b_rd : '0;

   // operands stay read for the held item while it waits
   assign rf_rs1_addr = pop ? head.instr_word[19:15] : rs1;
   assign rf_rs2_addr = pop ? head.instr_word[24:20] : rs2;

   assign immi = {{20{w[31]}}, w[31:20]};
   assign imms = {{20{w[31]}}, w[31:25], w[11:7]};
   assign immb = {{19{w[31]}}, w[31], w[7], w[30:25], w[11:8], 1'b0};
   assign immj = {{11{w[31]}}, w[31], w[19:12], w[20], w[30:21], 1'b0};
   assign immu = {w[31:12], 12'd0};
   assign prod = a * b;

   always_comb begin
      ex_next   = pc_ff + 32'd4;
      ex_v      = '0;
      ex_addr   = '0;
      ex_wr     = 1'b0;
      ex_st     = 1'b0;
      ex_status = rvs_pkg::ST_OK;
      unique case (op)
         rvs_pkg::OP_R: begin
            ex_wr = 1'b1;
            priority if (f3 == rvs_pkg::F3_ADD && f7 == rvs_pkg::F7_BASE) ex_v = a + b;
            else if (f3 == rvs_pkg::F3_ADD && f7 == rvs_pkg::F7_ALT) ex_v = a - b;
            else if (f3 == rvs_pkg::F3_ADD && f7 == rvs_pkg::F7_MUL) ex_v = prod;
            else if (f3 == rvs_pkg::F3_AND && f7 == rvs_pkg::F7_BASE) ex_v = a & b;
            else if (f3 == rvs_pkg::F3_OR && f7 == rvs_pkg::F7_BASE) ex_v = a | b;
            else if (f3 == rvs_pkg::F3_XOR && f7 == rvs_pkg::F7_BASE) ex_v = a ^ b;
            else if (f3 == rvs_pkg::F3_SLL && f7 == rvs_pkg::F7_BASE) ex_v = a << b[4:0];
            else if (f3 == rvs_pkg::F3_SR && f7 == rvs_pkg::F7_BASE) ex_v = a >> b[4:0];
            else if (f3 == rvs_pkg::F3_SR && f7 == rvs_pkg::F7_ALT)
               ex_v = 32'($signed(a) >>> b[4:0]);
            else if (f3 == rvs_pkg::F3_SLT && f7 == rvs_pkg::F7_BASE)
               ex_v = {31'd0, $signed(a) < $signed(b)};
            else if ((f3 == rvs_pkg::F3_XOR || f3 == rvs_pkg::F3_OR)
                     && f7 == rvs_pkg::F7_MUL) begin
               if (b == '0) begin
                  ex_status = rvs_pkg::ST_DIVZERO;
                  ex_wr     = 1'b0;
               end
            end else begin
               ex_status = rvs_pkg::ST_ILLEGAL;
               ex_wr     = 1'b0;
            end
         end
         rvs_pkg::OP_I: begin
            ex_wr = 1'b1;
            unique case (f3)
               rvs_pkg::F3_ADD: ex_v = a + immi;
               rvs_pkg::F3_AND: ex_v = a & immi;
               rvs_pkg::F3_OR:  ex_v = a | immi;
               default: begin
                  ex_status = rvs_pkg::ST_ILLEGAL;
                  ex_wr     = 1'b0;
               end
            endcase
         end
         rvs_pkg::OP_LOAD: begin
            if (f3 <= rvs_pkg::F3_WORD) begin
               ex_addr = a + immi;
               ex_wr   = 1'b1;
            end else begin
               ex_status = rvs_pkg::ST_ILLEGAL;
            end
         end
         rvs_pkg::OP_STORE: begin
            if (f3 <= rvs_pkg::F3_WORD) begin
               ex_addr = a + imms;
               ex_st   = 1'b1;
            end else begin
               ex_status = rvs_pkg::ST_ILLEGAL;
            end
         end
         rvs_pkg::OP_BRANCH: begin
            unique case (f3)
               rvs_pkg::F3_BEQ: if (a == b) ex_next = pc_ff + immb;
               rvs_pkg::F3_BNE: if (a != b) ex_next = pc_ff + immb;
               rvs_pkg::F3_BLT: if ($signed(a) < $signed(b)) ex_next = pc_ff + immb;
               rvs_pkg::F3_BGE: if (!($signed(a) < $signed(b))) ex_next = pc_ff + immb;
               default: ex_status = rvs_pkg::ST_ILLEGAL;
            endcase
         end
         rvs_pkg::OP_LUI: begin
            ex_v  = immu;
            ex_wr = 1'b1;
         end
         rvs_pkg::OP_AUIPC: begin
            ex_v  = pc_ff + immu;
            ex_wr = 1'b1;
         end
         rvs_pkg::OP_JAL: begin
            ex_v    = pc_ff + 32'd4;
            ex_next = pc_ff + immj;
            ex_wr   = 1'b1;
         end
         rvs_pkg::OP_JALR: begin
            if (f3 == rvs_pkg::F3_ADD) begin
               ex_v    = pc_ff + 32'd4;
               ex_next = (a + immi) & 32'hFFFF_FFFE;
               ex_wr   = 1'b1;
            end else begin
               ex_status = rvs_pkg::ST_ILLEGAL;
            end
         end
         default: ex_status = rvs_pkg::ST_ILLEGAL;
      endcase
   end

   assign div_start = go && item_ff.kind == rvs_pkg::KIND_DIVREM && b != '0;

   always_comb begin
      dm_we    = 1'b0;
      dm_waddr = clr_ff;
      dm_wdata = '0;
      if (state_ff == S_CLR) begin
         dm_we = 1'b1;
      end else if (go && item_ff.kind == rvs_pkg::KIND_PRELOAD) begin
         dm_we    = 1'b1;
         dm_waddr = item_ff.preload_addr[AW+1:2];
         dm_wdata = item_ff.preload_data;
      end else if (go && ex_st) begin
         dm_we    = 1'b1;
         dm_waddr = ex_addr[AW+1:2];
         dm_wdata = b;
      end
   end

   always_comb begin
      rf_we = 1'b0;
      rf_wa = rd;
      rf_wd = ex_v;
      if (state_ff == S_LOAD && out_free) begin
         rf_we = rd != '0;
         rf_wd = dm_rd;
      end else if (state_ff == S_DIV && div_done && out_free) begin
         rf_we = rd != '0;
         rf_wd = div_result;
      end else if (go && item_ff.kind == rvs_pkg::KIND_OTHER) begin
         rf_we = ex_wr && rd != '0;
      end
   end

   rvs_ram #(.WIDTH(32), .DEPTH(rvs_pkg::REG_COUNT)) u_rf_a (
      .clock(clock), .wr_en(rf_we), .wr_addr(rf_wa), .wr_data(rf_wd),
      .rd_addr(rf_rs1_addr), .rd_data(rf_a_rd));

   rvs_ram #(.WIDTH(32), .DEPTH(rvs_pkg::REG_COUNT)) u_rf_b (
      .clock(clock), .wr_en(rf_we), .wr_addr(rf_wa), .wr_data(rf_wd),
      .rd_addr(rf_rs2_addr), .rd_data(rf_b_rd));

   rvs_ram #(.WIDTH(32), .DEPTH(DMEM_DEPTH)) u_dmem (
      .clock(clock), .wr_en(dm_we), .wr_addr(dm_waddr), .wr_data(dm_wdata),
      .rd_addr(ex_addr[AW+1:2]), .rd_data(dm_rd));

   rvs_div u_div (
      .clock(clock), .reset(reset), .start(div_start), .want_rem(f3 == rvs_pkg::F3_OR),
      .dividend(a), .divisor(b), .done(div_done), .result(div_result));

   always_ff @(posedge clock) begin
      if (pop) begin
         item_ff <= head;
      end
      if (reset) begin
         state_ff     <= S_CLR;
         clr_ff       <= '0;
         pc_ff        <= '0;
         rf_valid_ff  <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         if (rsp_valid_ff && rsp_ready) begin
            rsp_valid_ff <= 1'b0;
         end
         if (rf_we) begin
            rf_valid_ff[rf_wa] <= 1'b1;
         end
         unique case (state_ff)
            S_CLR: begin
               clr_ff <= clr_ff + 1'b1;
               if (clr_ff == AW'(DMEM_DEPTH-1)) begin
                  state_ff <= S_IDLE;
               end
            end
            S_IDLE: begin
               if (head_valid) begin
                  state_ff <= S_EXEC;
               end
            end
            S_EXEC: begin
               if (out_free) begin
                  item_pc_ff <= pc_ff;
                  if (item_ff.kind == rvs_pkg::KIND_PRELOAD) begin
                     rsp_valid_ff    <= 1'b1;
                     next_pc_ff      <= pc_ff;
                     wb_enable_ff    <= 1'b0;
                     wb_reg_ff       <= '0;
                     wb_value_ff     <= '0;
                     store_enable_ff <= 1'b1;
                     mem_address_ff  <= item_ff.preload_addr;
                     status_ff       <= rvs_pkg::ST_OK;
                     state_ff        <= S_IDLE;
                  end else if (item_ff.kind == rvs_pkg::KIND_LOAD) begin
                     addr_pend_ff <= ex_addr;
                     state_ff     <= S_LOAD;
                  end else if (div_start) begin
                     state_ff <= S_DIV;
                  end else begin
                     rsp_valid_ff    <= 1'b1;
                     next_pc_ff      <= ex_next;
                     wb_enable_ff    <= ex_wr && rd != '0;
                     wb_reg_ff       <= (ex_wr && rd != '0) ? rd : '0;
                     wb_value_ff     <= (ex_wr && rd != '0) ? ex_v : '0;
                     store_enable_ff <= ex_st;
                     mem_address_ff  <= ex_addr;
                     status_ff       <= ex_status;
                     pc_ff           <= ex_next;
                     state_ff        <= S_IDLE;
                  end
               end
            end
            S_LOAD: begin
               if (out_free) begin
                  rsp_valid_ff    <= 1'b1;
                  next_pc_ff      <= pc_ff + 32'd4;
                  wb_enable_ff    <= rd != '0;
                  wb_reg_ff       <= rd;
                  wb_value_ff     <= (rd != '0) ? dm_rd : '0;
                  store_enable_ff <= 1'b0;
                  mem_address_ff  <= addr_pend_ff;
                  status_ff       <= rvs_pkg::ST_OK;
                  pc_ff           <= pc_ff + 32'd4;
                  state_ff        <= S_IDLE;
               end
            end
            S_DIV: begin
               if (div_done && out_free) begin
                  rsp_valid_ff    <= 1'b1;
                  next_pc_ff      <= pc_ff + 32'd4;
                  wb_enable_ff    <= rd != '0;
                  wb_reg_ff       <= rd;
                  wb_value_ff     <= (rd != '0) ? div_result : '0;
                  store_enable_ff <= 1'b0;
                  mem_address_ff  <= '0;
                  status_ff       <= rvs_pkg::ST_OK;
                  pc_ff           <= pc_ff + 32'd4;
                  state_ff        <= S_IDLE;
               end
            end
            default: state_ff <= S_IDLE;
         endcase
      end
   end

   assign rsp_valid      = rsp_valid_ff;
   assign o_item_pc      = item_pc_ff;
   assign o_next_pc      = next_pc_ff;
   assign o_wb_enable    = wb_enable_ff;
   assign o_wb_reg       = wb_reg_ff;
   assign o_wb_value     = wb_value_ff;
   assign o_store_enable = store_enable_ff;
   assign o_mem_address  = mem_address_ff;
   assign o_status       = status_ff;

   a_x0_never_written: assert property (@(posedge clock) disable iff (reset)
      rsp_valid_ff && wb_enable_ff |-> wb_reg_ff != '0)
      else $error("write-back to x0 reported");

   a_fault_no_effects: assert property (@(posedge clock) disable iff (reset)
      rsp_valid_ff && status_ff != rvs_pkg::ST_OK |-> !wb_enable_ff && !store_enable_ff)
      else $error("faulting item has side effects");

   a_no_result_while_clearing: assert property (@(posedge clock) disable iff (reset)
      state_ff == S_CLR |-> !rsp_valid_ff)
      else $error("result during clearing pass");

   a_pop_has_item: assert property (@(posedge clock) disable iff (reset)
      pop |=> state_ff == S_EXEC)
      else $error("popped item not executed");

endmodule

// ----- sv/rv32_subset_execute_core.sv -----
// rv32_subset_execute_core: top level of the RV32 subset execute core.
// Depends on rvs_pkg, rvs_front and rvs_back.
//
// Usage:
//  req channel: one transaction per item. tuser is the action (0 execute the
//  instruction word, 1 preload a data word); tdata carries instr_word,
//  preload_addr and preload_data.
//  rsp channel: one result transaction per item, in order.
//  Flow: an item enters a two-entry queue; the back-end sequencer pops it and
//  reads the register file, then executes it and registers the result. Loads
//  add a registered data store read; DIV/REM wait for the divider (32 divider
//  steps, one quotient bit per cycle). The sequencer pops the next item only
//  once the current item's result is registered, which a full result register
//  can delay.
//  Reset: synchronous. After reset a clearing pass writes zeros to every word
//  of the data store; req_tready stays low during it.
//  A stalled rsp_tready holds the result; the queue keeps taking requests
//  until it is full.
module rv32_subset_execute_core #(
   parameter int unsigned DMEM_DEPTH = rvs_pkg::DMEM_DEPTH_DEF
) (
   input  logic         clock,
   input  logic         reset,
   input  logic         req_tvalid,
   output logic         req_tready,
   input  logic [95:0]  req_tdata,  // instr_word, preload_addr, preload_data
   input  logic         req_tuser,  // action
   output logic         rsp_tvalid,
   input  logic         rsp_tready,
   output logic [143:0] rsp_tdata   // item_pc, next_pc, wb_enable, wb_reg, wb_value,
                                    // store_enable, mem_address, status, zero pad
);

   rvs_pkg::item_type head;
   logic              head_valid, pop, clearing;
   logic [31:0]       item_pc, next_pc, wb_value, mem_address;
   logic              wb_enable, store_enable;
   logic [4:0]        wb_reg;
   logic [1:0]        status;

   rvs_front u_front (
      .clock(clock), .reset(reset), .clearing(clearing),
      .req_tvalid(req_tvalid), .req_tready(req_tready),
      .req_tdata(req_tdata), .req_tuser(req_tuser),
      .head(head), .head_valid(head_valid), .pop(pop));

   rvs_back #(.DMEM_DEPTH(DMEM_DEPTH)) u_back (
      .clock(clock), .reset(reset), .head(head), .head_valid(head_valid),
      .pop(pop), .clearing(clearing),
      .rsp_valid(rsp_tvalid), .rsp_ready(rsp_tready),
      .o_item_pc(item_pc), .o_next_pc(next_pc), .o_wb_enable(wb_enable),
      .o_wb_reg(wb_reg), .o_wb_value(wb_value), .o_store_enable(store_enable),
      .o_mem_address(mem_address), .o_status(status));

   assign rsp_tdata = {7'd0, status, mem_address, store_enable, wb_value, wb_reg,
                       wb_enable, next_pc, item_pc};

endmodule
